>>> rtl/tbik_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the two-bone bend angle unit.
// No dependencies; every other file refers to it by scoped names.
package tbik_pkg;

	localparam int ANGLE_FRAC_BITS  = 16;
	localparam int CORDIC_STEPS_DEF = 18;

	// widths of the datapath
	localparam int COORD_W = 24;
	localparam int REACH_W = 23;
	localparam int PROD_W  = 48;
	localparam int D_W     = 52;
	localparam int P_W     = 49;
	localparam int DMAG_W  = 50;
	localparam int NRM_W   = 48;
	localparam int NX_W    = 50;
	localparam int CX_W    = 34;
	localparam int ANG_W   = 36;
	localparam int K_W     = 6;
	localparam int MAG_W   = 32;
	localparam int GAIN_W  = 30;
	localparam int DSC_W   = 78;
	localparam int DIV_Q_BITS = 30;
	localparam int CQ_W    = 31;
	localparam int RAD_W   = 61;
	localparam int SQRT_STEPS = 31;
	localparam int OUT_W   = 19;

	// normalization: larger component of p ends in [2^45, 2^46) unless it starts at 2^46 or more
	localparam int NORM_TOP   = 46;
	localparam int NORM_STEPS = 6;
	localparam int XF_SHIFT   = 17;

	localparam logic signed [ANG_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q32  = 36'sd26986075409;
	localparam logic [GAIN_W-1:0]       INV_GAIN_Q30 = 30'd652032874;
	localparam logic [CQ_W-1:0]         ONE_Q30 = 31'h4000_0000;
	localparam logic [OUT_W-1:0]        OUT_MAX = 19'h7FFFF;

	typedef struct packed {
		logic en;
		logic valid;
	} stage_ctl_t;

	// atan(2^-i) in Q32 radians
	function automatic logic signed [ANG_W-1:0] atan_step(input int i);
		logic signed [ANG_W-1:0] r;
		begin
			case (i)
				0:  r = 36'sd3373259426;
				1:  r = 36'sd1991351318;
				2:  r = 36'sd1052175346;
				3:  r = 36'sd534100635;
				4:  r = 36'sd268086748;
				5:  r = 36'sd134174063;
				6:  r = 36'sd67103403;
				7:  r = 36'sd33553749;
				8:  r = 36'sd16777131;
				9:  r = 36'sd8388597;
				10: r = 36'sd4194303;
				11: r = 36'sd2097152;
				12: r = 36'sd1048576;
				default: begin
					if (i < 32) begin
						r = ANG_W'(64'sd1 <<< (32 - i));
					end else begin
						r = '0;
					end
				end
			endcase
			return r;
		end
	endfunction

endpackage

>>> rtl/two_bone_ik_bend_angle_unit.sv
// Two-bone IK bend angle unit: top level. Instantiates tbik_norm, tbik_cordic (twice),
// tbik_div and tbik_sqrt; constants and types come from tbik_pkg.
//
// The unit takes one word per clock while s_tready is high: middle joint offset m, end joint
// offset e (signed Q11.12) and the reach r (unsigned Q11.12), and returns one word per
// input holding the bend angle max(0, acos(clamp(d/|p|, -1, 1)) - atan2(p.y, p.x)) as
// unsigned Q3.16 radians, with d = (r^2 - |m|^2 - |e|^2)/2 - m.x*e.x and
// p = (m.y*e.y + m.z*e.z, m.y*e.z - e.y*m.z). When p is exactly zero the ratio becomes the
// sign of d and the degenerate flag is set. Throughput is one word per cycle while the output
// is not stalled; each word passes through the two serial CORDIC pipelines, the 30-stage
// divider and the 31-stage square root. The whole pipeline advances together; a two-entry
// output stage (output register plus skid register) lets one more word enter after the
// output stalls. No state is kept between words.
module two_bone_ik_bend_angle_unit #(
	parameter int CORDIC_STEPS = tbik_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave side
	input  logic         s_tvalid,
	output logic         s_tready,
	// mid_x[23:0], mid_y[47:24], mid_z[71:48], end_x[95:72], end_y[119:96],
	// end_z[143:120], reach[166:144], zero pad [167]
	input  logic [167:0] s_tdata,
	// master side
	output logic         m_tvalid,
	input  logic         m_tready,
	// bend_angle[18:0], zero pad [23:19]
	output logic [23:0]  m_tdata,
	// degenerate[0]
	output logic [0:0]   m_tuser
);
	localparam int CW  = tbik_pkg::COORD_W;
	localparam int PW  = tbik_pkg::PROD_W;
	localparam int DW  = tbik_pkg::D_W;
	localparam int PPW = tbik_pkg::P_W;
	localparam int AW  = tbik_pkg::ANG_W;
	localparam int MW  = tbik_pkg::MAG_W;
	localparam int OW  = tbik_pkg::OUT_W;
	localparam int AFB = tbik_pkg::ANGLE_FRAC_BITS;

	// side bundle widths
	localparam int NSIDE_W = tbik_pkg::DMAG_W + 3;
	localparam int C1SIDE_W = tbik_pkg::K_W + NSIDE_W;
	localparam int DSIDE_W = AW + 4;
	localparam int SSIDE_W = 32 + AW + 1;
	localparam int C2SIDE_W = AW + 1;

	logic en;
	logic skid_v_q;

	// input field split
	logic signed [CW-1:0] mid_x, mid_y, mid_z, end_x, end_y, end_z;
	logic [tbik_pkg::REACH_W-1:0] reach;

	assign mid_x = $signed(s_tdata[23:0]);
	assign mid_y = $signed(s_tdata[47:24]);
	assign mid_z = $signed(s_tdata[71:48]);
	assign end_x = $signed(s_tdata[95:72]);
	assign end_y = $signed(s_tdata[119:96]);
	assign end_z = $signed(s_tdata[143:120]);
	assign reach = s_tdata[166:144];

	// pipeline moves whenever the skid register is empty
	assign en       = 1'b1 & ~skid_v_q;
	assign s_tready = en;

	//------------------------------------------------------------------
	// s1: all products in parallel
	//------------------------------------------------------------------
	logic               v_s1;
	logic signed [PW-1:0] mxmx_s1, mymy_s1, mzmz_s1, exex_s1, eyey_s1, ezez_s1;
	logic signed [PW-1:0] mxex_s1, myey_s1, mzez_s1, myez_s1, eymz_s1;
	logic [2*tbik_pkg::REACH_W-1:0] rr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mxmx_s1 <= mid_x * mid_x;
			mymy_s1 <= mid_y * mid_y;
			mzmz_s1 <= mid_z * mid_z;
			exex_s1 <= end_x * end_x;
			eyey_s1 <= end_y * end_y;
			ezez_s1 <= end_z * end_z;
			mxex_s1 <= mid_x * end_x;
			myey_s1 <= mid_y * end_y;
			mzez_s1 <= mid_z * end_z;
			myez_s1 <= mid_y * end_z;
			eymz_s1 <= end_y * mid_z;
			rr_s1   <= reach * reach;
		end
	end

	//------------------------------------------------------------------
	// s2: partial sums of 2d, and p
	//------------------------------------------------------------------
	logic                  v_s2;
	logic signed [DW-1:0]  da_s2, db_s2;
	logic signed [PPW-1:0] px_s2, py_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			da_s2 <= $signed({{(DW-2*tbik_pkg::REACH_W){1'b0}}, rr_s1})
				- DW'(mxmx_s1) - DW'(mymy_s1) - DW'(mzmz_s1);
			db_s2 <= DW'(exex_s1) + DW'(eyey_s1) + DW'(ezez_s1) + (DW'(mxex_s1) <<< 1);
			px_s2 <= PPW'(myey_s1) + PPW'(mzez_s1);
			py_s2 <= PPW'(myez_s1) - PPW'(eymz_s1);
		end
	end

	//------------------------------------------------------------------
	// s3: 2d, magnitudes of p, zero cross term
	//------------------------------------------------------------------
	logic                        v_s3;
	logic signed [DW-1:0]        d2_s3;
	logic [tbik_pkg::NRM_W-1:0]  ax_s3, ay_s3;
	logic                        sx_s3, sy_s3, degen_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3    <= da_s2 - db_s2;
			ax_s3    <= tbik_pkg::NRM_W'(px_s2[PPW-1] ? -px_s2 : px_s2);
			ay_s3    <= tbik_pkg::NRM_W'(py_s2[PPW-1] ? -py_s2 : py_s2);
			sx_s3    <= px_s2[PPW-1];
			sy_s3    <= py_s2[PPW-1];
			degen_s3 <= (px_s2 == '0) && (py_s2 == '0);
		end
	end

	//------------------------------------------------------------------
	// s4: |2d| and its sign
	//------------------------------------------------------------------
	logic                        v_s4;
	logic [tbik_pkg::DMAG_W-1:0] dmag_s4;
	logic                        dneg_s4, dzero_s4;
	logic [tbik_pkg::NRM_W-1:0]  ax_s4, ay_s4;
	logic                        sx_s4, sy_s4, degen_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s4  <= tbik_pkg::DMAG_W'(d2_s3[DW-1] ? -d2_s3 : d2_s3);
			dneg_s4  <= d2_s3[DW-1];
			dzero_s4 <= (d2_s3 == '0);
			ax_s4    <= ax_s3;
			ay_s4    <= ay_s3;
			sx_s4    <= sx_s3;
			sy_s4    <= sy_s3;
			degen_s4 <= degen_s3;
		end
	end

	//------------------------------------------------------------------
	// normalize p, then angle and magnitude of p
	//------------------------------------------------------------------
	tbik_pkg::stage_ctl_t        ctl_nrm;
	logic                        nrm_v;
	logic signed [tbik_pkg::NX_W-1:0] nrm_x, nrm_y;
	logic [tbik_pkg::K_W-1:0]    nrm_k;
	logic [NSIDE_W-1:0]          nrm_side;

	assign ctl_nrm = '{en: en, valid: v_s4};

	tbik_norm #(
		.SIDE_W (NSIDE_W)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_nrm),
		.ax        (ax_s4),
		.ay        (ay_s4),
		.sx        (sx_s4),
		.sy        (sy_s4),
		.side_in   ({dmag_s4, dneg_s4, dzero_s4, degen_s4}),
		.valid_out (nrm_v),
		.nx        (nrm_x),
		.ny        (nrm_y),
		.k         (nrm_k),
		.side_out  (nrm_side)
	);

	tbik_pkg::stage_ctl_t             ctl_c1;
	logic                             c1_v;
	logic signed [AW-1:0]             c1_ang;
	logic signed [tbik_pkg::NX_W-1:0] c1_x;
	logic [C1SIDE_W-1:0]              c1_side;

	assign ctl_c1 = '{en: en, valid: nrm_v};

	tbik_cordic #(
		.W      (tbik_pkg::NX_W),
		.STEPS  (CORDIC_STEPS),
		.SIDE_W (C1SIDE_W)
	) u_cordic_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_c1),
		.x_in      (nrm_x),
		.y_in      (nrm_y),
		.side_in   ({nrm_k, nrm_side}),
		.valid_out (c1_v),
		.angle     (c1_ang),
		.x_out     (c1_x),
		.side_out  (c1_side)
	);

	logic [tbik_pkg::K_W-1:0]    c1_k;
	logic [tbik_pkg::DMAG_W-1:0] c1_dmag;
	logic                        c1_dneg, c1_dzero, c1_degen;

	assign {c1_k, c1_dmag, c1_dneg, c1_dzero, c1_degen} = c1_side;

	//------------------------------------------------------------------
	// s5: |p| through the inverse gain; |2d| scaled to the same exponent
	//------------------------------------------------------------------
	localparam logic [tbik_pkg::K_W-1:0] XF_SH = tbik_pkg::K_W'(tbik_pkg::XF_SHIFT);

	logic                           v_s5;
	logic [MW-1:0]                  mag_s5;
	logic [MW-1:0]                  dsc_s5;
	logic                           ovf_s5;
	logic signed [AW-1:0]           pang_s5;
	logic                           dneg_s5, dzero_s5, degen_s5;
	logic [MW+tbik_pkg::GAIN_W-1:0] gprod;
	logic [tbik_pkg::DSC_W-1:0]     dsw;

	assign gprod = c1_x[tbik_pkg::XF_SHIFT+MW-1:tbik_pkg::XF_SHIFT] * tbik_pkg::INV_GAIN_Q30;

	always_comb begin
		if (c1_k >= XF_SH) begin
			dsw = {{(tbik_pkg::DSC_W-tbik_pkg::DMAG_W){1'b0}}, c1_dmag} << (c1_k - XF_SH);
		end else begin
			dsw = {{(tbik_pkg::DSC_W-tbik_pkg::DMAG_W){1'b0}}, c1_dmag} >> (XF_SH - c1_k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= c1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5   <= gprod[MW+tbik_pkg::GAIN_W-1:tbik_pkg::GAIN_W];
			dsc_s5   <= dsw[MW-1:0];
			ovf_s5   <= |dsw[tbik_pkg::DSC_W-1:MW];
			pang_s5  <= c1_degen ? '0 : c1_ang;
			dneg_s5  <= c1_dneg;
			dzero_s5 <= c1_dzero;
			degen_s5 <= c1_degen;
		end
	end

	//------------------------------------------------------------------
	// s6: ratio saturates when |d| >= |p|
	//------------------------------------------------------------------
	logic                 v_s6;
	logic [MW-1:0]        mag_s6, dsc_s6;
	logic                 sat_s6;
	logic signed [AW-1:0] pang_s6;
	logic                 dneg_s6, dzero_s6, degen_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s6   <= mag_s5;
			dsc_s6   <= dsc_s5;
			sat_s6   <= ovf_s5 || ({1'b0, dsc_s5} >= {mag_s5, 1'b0});
			pang_s6  <= pang_s5;
			dneg_s6  <= dneg_s5;
			dzero_s6 <= dzero_s5;
			degen_s6 <= degen_s5;
		end
	end

	tbik_pkg::stage_ctl_t              ctl_div;
	logic                              div_v;
	logic [tbik_pkg::DIV_Q_BITS-1:0]   div_q;
	logic [DSIDE_W-1:0]                div_side;

	assign ctl_div = '{en: en, valid: v_s6};

	tbik_div #(
		.SIDE_W (DSIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_div),
		.num       (dsc_s6),
		.den       (mag_s6),
		.side_in   ({pang_s6, sat_s6, dneg_s6, dzero_s6, degen_s6}),
		.valid_out (div_v),
		.quot      (div_q),
		.side_out  (div_side)
	);

	logic signed [AW-1:0] dv_pang;
	logic                 dv_sat, dv_dneg, dv_dzero, dv_degen;

	assign {dv_pang, dv_sat, dv_dneg, dv_dzero, dv_degen} = div_side;

	//------------------------------------------------------------------
	// s7: ratio magnitude, special cases
	//------------------------------------------------------------------
	logic                       v_s7;
	logic [tbik_pkg::CQ_W-1:0]  cq_s7;
	logic signed [AW-1:0]       pang_s7;
	logic                       dneg_s7, degen_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (dv_degen) begin
				cq_s7 <= dv_dzero ? '0 : tbik_pkg::ONE_Q30;
			end else if (dv_sat) begin
				cq_s7 <= tbik_pkg::ONE_Q30;
			end else begin
				cq_s7 <= {1'b0, div_q};
			end
			pang_s7  <= dv_pang;
			dneg_s7  <= dv_dneg;
			degen_s7 <= dv_degen;
		end
	end

	//------------------------------------------------------------------
	// s8: signed cosine and its square
	//------------------------------------------------------------------
	logic                            v_s8;
	logic signed [31:0]              c_s8;
	logic [2*tbik_pkg::CQ_W-1:0]     sq_s8;
	logic signed [AW-1:0]            pang_s8;
	logic                            degen_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8     <= dneg_s7 ? -$signed({1'b0, cq_s7}) : $signed({1'b0, cq_s7});
			sq_s8    <= cq_s7 * cq_s7;
			pang_s8  <= pang_s7;
			degen_s8 <= degen_s7;
		end
	end

	//------------------------------------------------------------------
	// sine = floor(sqrt(2^60 - c^2)), then acos via atan2(sine, c)
	//------------------------------------------------------------------
	localparam logic [tbik_pkg::RAD_W-1:0] RAD_ONE = tbik_pkg::RAD_W'(1) << 60;

	tbik_pkg::stage_ctl_t       ctl_sq;
	logic [tbik_pkg::RAD_W-1:0] rad_in;
	logic                       sq_v;
	logic [tbik_pkg::CQ_W-1:0]  sq_root;
	logic [SSIDE_W-1:0]         sq_side;

	assign ctl_sq = '{en: en, valid: v_s8};
	assign rad_in = RAD_ONE - sq_s8[tbik_pkg::RAD_W-1:0];

	tbik_sqrt #(
		.SIDE_W (SSIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_sq),
		.rad       (rad_in),
		.side_in   ({c_s8, pang_s8, degen_s8}),
		.valid_out (sq_v),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	logic signed [31:0]   sq_c;
	logic signed [AW-1:0] sq_pang;
	logic                 sq_degen;

	assign {sq_c, sq_pang, sq_degen} = sq_side;

	tbik_pkg::stage_ctl_t              ctl_c2;
	logic                              c2_v;
	logic signed [AW-1:0]              c2_ang;
	logic signed [tbik_pkg::CX_W-1:0]  c2_x;
	logic [C2SIDE_W-1:0]               c2_side;

	assign ctl_c2 = '{en: en, valid: sq_v};

	tbik_cordic #(
		.W      (tbik_pkg::CX_W),
		.STEPS  (CORDIC_STEPS),
		.SIDE_W (C2SIDE_W)
	) u_cordic_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_c2),
		.x_in      (tbik_pkg::CX_W'(sq_c)),
		.y_in      ($signed({{(tbik_pkg::CX_W-tbik_pkg::CQ_W){1'b0}}, sq_root})),
		.side_in   ({sq_pang, sq_degen}),
		.valid_out (c2_v),
		.angle     (c2_ang),
		.x_out     (c2_x),
		.side_out  (c2_side)
	);

	logic signed [AW-1:0] c2_pang;
	logic                 c2_degen;

	assign {c2_pang, c2_degen} = c2_side;

	//------------------------------------------------------------------
	// s9: difference limited to [0, 2*pi]
	//------------------------------------------------------------------
	logic                 v_s9;
	logic [AW-2:0]        diff_s9;
	logic                 degen_s9;
	logic signed [AW:0]   diff;
	logic                 c2_xneg;

	// magnitude output of the acos CORDIC is unused; its sign is never set
	assign c2_xneg = c2_x[tbik_pkg::CX_W-1];
	assign diff    = (AW+1)'(c2_ang) - (AW+1)'(c2_pang);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= c2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (diff[AW] || (diff == '0)) begin
				diff_s9 <= '0;
			end else if (diff > (AW+1)'(tbik_pkg::TWO_PI_Q32)) begin
				diff_s9 <= (AW-1)'(tbik_pkg::TWO_PI_Q32);
			end else begin
				diff_s9 <= diff[AW-2:0];
			end
			degen_s9 <= c2_degen | (c2_xneg & 1'b0);
		end
	end

	//------------------------------------------------------------------
	// s10: round half up to the output fraction and saturate
	//------------------------------------------------------------------
	localparam logic [AW:0] RND_HALF = (AW+1)'(1) << (31 - AFB);

	logic          v_s10;
	logic [OW-1:0] ang_s10;
	logic          degen_s10;
	logic [AW:0]   rnd;
	logic [AW:0]   rsh;

	assign rnd = {2'b00, diff_s9} + RND_HALF;
	assign rsh = rnd >> (32 - AFB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s10   <= (rsh > (AW+1)'(tbik_pkg::OUT_MAX)) ? tbik_pkg::OUT_MAX : rsh[OW-1:0];
			degen_s10 <= degen_s9;
		end
	end

	//------------------------------------------------------------------
	// output register with skid; a word leaves s10 when en is high
	//------------------------------------------------------------------
	logic          out_v_q;
	logic [OW-1:0] out_ang_q, skid_ang_q;
	logic          out_dg_q, skid_dg_q;
	logic          out_take;

	assign out_take = out_v_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			priority if (skid_v_q) begin
				if (out_take) begin
					skid_v_q <= 1'b0;
				end
			end else if (v_s10) begin
				if (!out_v_q || out_take) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (skid_v_q) begin
			if (out_take) begin
				out_ang_q <= skid_ang_q;
				out_dg_q  <= skid_dg_q;
			end
		end else if (v_s10) begin
			if (!out_v_q || out_take) begin
				out_ang_q <= ang_s10;
				out_dg_q  <= degen_s10;
			end else begin
				skid_ang_q <= ang_s10;
				skid_dg_q  <= degen_s10;
			end
		end else begin
			out_ang_q <= out_ang_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(24-OW){1'b0}}, out_ang_q};
	assign m_tuser  = out_dg_q;

endmodule

>>> rtl/tbik_norm.sv
// Pipelined normalizing shifter: one binary shift decision per stage.
// Depends on tbik_pkg.
module tbik_norm #(
	parameter int SIDE_W = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tbik_pkg::stage_ctl_t                   ctl,
	input  logic [tbik_pkg::NRM_W-1:0]             ax,
	input  logic [tbik_pkg::NRM_W-1:0]             ay,
	input  logic                                   sx,
	input  logic                                   sy,
	input  logic [SIDE_W-1:0]                      side_in,
	output logic                                   valid_out,
	output logic signed [tbik_pkg::NX_W-1:0]       nx,
	output logic signed [tbik_pkg::NX_W-1:0]       ny,
	output logic [tbik_pkg::K_W-1:0]               k,
	output logic [SIDE_W-1:0]                      side_out
);
	localparam int N = tbik_pkg::NORM_STEPS;
	localparam int W = tbik_pkg::NRM_W;

	logic [W-1:0]                a_s  [1:N];
	logic [W-1:0]                b_s  [1:N];
	logic [tbik_pkg::K_W-1:0]    k_s  [1:N];
	logic [1:0]                  sg_s [1:N];
	logic [SIDE_W-1:0]           sd_s [1:N];
	logic                        v_s  [1:N];

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam int SH = 1 << (N - 1 - i);
		localparam logic [W-1:0] LIM = W'(1) << (tbik_pkg::NORM_TOP - SH);
		localparam logic [tbik_pkg::K_W-1:0] SHK = tbik_pkg::K_W'(SH);
		logic [W-1:0]             a_i;
		logic [W-1:0]             b_i;
		logic [tbik_pkg::K_W-1:0] k_i;
		logic [1:0]               sg_i;
		logic [SIDE_W-1:0]        sd_i;
		logic                     v_i;
		if (i == 0) begin : g_in
			assign a_i  = ax;
			assign b_i  = ay;
			assign k_i  = '0;
			assign sg_i = {sy, sx};
			assign sd_i = side_in;
			assign v_i  = ctl.valid;
		end else begin : g_in
			assign a_i  = a_s[i];
			assign b_i  = b_s[i];
			assign k_i  = k_s[i];
			assign sg_i = sg_s[i];
			assign sd_i = sd_s[i];
			assign v_i  = v_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				v_s[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if ((a_i | b_i) < LIM) begin
					a_s[i+1] <= a_i << SH;
					b_s[i+1] <= b_i << SH;
					k_s[i+1] <= k_i + SHK;
				end else begin
					a_s[i+1] <= a_i;
					b_s[i+1] <= b_i;
					k_s[i+1] <= k_i;
				end
				sg_s[i+1] <= sg_i;
				sd_s[i+1] <= sd_i;
			end
		end
	end

	always_comb begin
		nx = $signed({{(tbik_pkg::NX_W-W){1'b0}}, a_s[N]});
		ny = $signed({{(tbik_pkg::NX_W-W){1'b0}}, b_s[N]});
		if (sg_s[N][0]) begin
			nx = -nx;
		end
		if (sg_s[N][1]) begin
			ny = -ny;
		end
	end

	assign k         = k_s[N];
	assign side_out  = sd_s[N];
	assign valid_out = v_s[N];

endmodule

>>> rtl/tbik_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in Q32 and the gain-scaled magnitude.
// One prerotation stage, then one micro-rotation per stage. Depends on tbik_pkg.
module tbik_cordic #(
	parameter int W      = tbik_pkg::CX_W,
	parameter int STEPS  = tbik_pkg::CORDIC_STEPS_DEF,
	parameter int SIDE_W = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tbik_pkg::stage_ctl_t                ctl,
	input  logic signed [W-1:0]                 x_in,
	input  logic signed [W-1:0]                 y_in,
	input  logic [SIDE_W-1:0]                   side_in,
	output logic                                valid_out,
	output logic signed [tbik_pkg::ANG_W-1:0]   angle,
	output logic signed [W-1:0]                 x_out,
	output logic [SIDE_W-1:0]                   side_out
);
	logic signed [W-1:0]               x_s  [0:STEPS];
	logic signed [W-1:0]               y_s  [0:STEPS];
	logic signed [tbik_pkg::ANG_W-1:0] z_s  [0:STEPS];
	logic                              zr_s [0:STEPS];
	logic [SIDE_W-1:0]                 sd_s [0:STEPS];
	logic                              v_s  [0:STEPS];

	// prerotation into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (ctl.en) begin
			v_s[0] <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (x_in[W-1]) begin
				if (!y_in[W-1]) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= tbik_pkg::HALF_PI_Q32;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -tbik_pkg::HALF_PI_Q32;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
			zr_s[0] <= (x_in == '0) && (y_in == '0);
			sd_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [tbik_pkg::ANG_W-1:0] AT = tbik_pkg::atan_step(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if (!y_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end
				zr_s[i+1] <= zr_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	// zero vector gives angle 0 and magnitude 0
	assign angle     = zr_s[STEPS] ? '0 : z_s[STEPS];
	assign x_out     = zr_s[STEPS] ? '0 : x_s[STEPS];
	assign side_out  = sd_s[STEPS];
	assign valid_out = v_s[STEPS];

endmodule

>>> rtl/tbik_div.sv
// Pipelined restoring divider: Q30 quotient of num * 2^29 / den, one bit per stage.
// Valid only for num < 2 * den. Depends on tbik_pkg.
module tbik_div #(
	parameter int SIDE_W = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tbik_pkg::stage_ctl_t                ctl,
	input  logic [tbik_pkg::MAG_W-1:0]          num,
	input  logic [tbik_pkg::MAG_W-1:0]          den,
	input  logic [SIDE_W-1:0]                   side_in,
	output logic                                valid_out,
	output logic [tbik_pkg::DIV_Q_BITS-1:0]     quot,
	output logic [SIDE_W-1:0]                   side_out
);
	localparam int QB = tbik_pkg::DIV_Q_BITS;
	localparam int MW = tbik_pkg::MAG_W;

	logic [MW-1:0]     rem_s [1:QB];
	logic [MW-1:0]     den_s [1:QB];
	logic [QB-1:0]     q_s   [1:QB];
	logic [SIDE_W-1:0] sd_s  [1:QB];
	logic              v_s   [1:QB];

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [MW:0]       t_i;
		logic [MW-1:0]     d_i;
		logic [QB-1:0]     q_i;
		logic [SIDE_W-1:0] sd_i;
		logic              v_i;
		if (i == 0) begin : g_in
			// top bit compares num itself against den
			assign t_i  = {1'b0, num};
			assign d_i  = den;
			assign q_i  = '0;
			assign sd_i = side_in;
			assign v_i  = ctl.valid;
		end else begin : g_in
			assign t_i  = {rem_s[i], 1'b0};
			assign d_i  = den_s[i];
			assign q_i  = q_s[i];
			assign sd_i = sd_s[i];
			assign v_i  = v_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				v_s[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if (t_i >= {1'b0, d_i}) begin
					rem_s[i+1] <= MW'(t_i - {1'b0, d_i});
					q_s[i+1]   <= {q_i[QB-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= MW'(t_i);
					q_s[i+1]   <= {q_i[QB-2:0], 1'b0};
				end
				den_s[i+1] <= d_i;
				sd_s[i+1]  <= sd_i;
			end
		end
	end

	assign quot      = q_s[QB];
	assign side_out  = sd_s[QB];
	assign valid_out = v_s[QB];

endmodule

>>> rtl/tbik_sqrt.sv
// Pipelined integer square root, one result bit per stage (floor of sqrt).
// Depends on tbik_pkg.
module tbik_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tbik_pkg::stage_ctl_t                ctl,
	input  logic [tbik_pkg::RAD_W-1:0]          rad,
	input  logic [SIDE_W-1:0]                   side_in,
	output logic                                valid_out,
	output logic [tbik_pkg::CQ_W-1:0]           root,
	output logic [SIDE_W-1:0]                   side_out
);
	localparam int N  = tbik_pkg::SQRT_STEPS;
	localparam int RW = tbik_pkg::RAD_W + 1;

	logic [RW-1:0]     v_rem [1:N];
	logic [RW-1:0]     r_s   [1:N];
	logic [SIDE_W-1:0] sd_s  [1:N];
	logic              v_s   [1:N];

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - i));
		logic [RW-1:0]     x_i;
		logic [RW-1:0]     r_i;
		logic [RW-1:0]     t_i;
		logic [SIDE_W-1:0] sd_i;
		logic              v_i;
		if (i == 0) begin : g_in
			assign x_i  = {1'b0, rad};
			assign r_i  = '0;
			assign sd_i = side_in;
			assign v_i  = ctl.valid;
		end else begin : g_in
			assign x_i  = v_rem[i];
			assign r_i  = r_s[i];
			assign sd_i = sd_s[i];
			assign v_i  = v_s[i];
		end
		assign t_i = r_i + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (ctl.en) begin
				v_s[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if (x_i >= t_i) begin
					v_rem[i+1] <= x_i - t_i;
					r_s[i+1]   <= (r_i >> 1) + BIT;
				end else begin
					v_rem[i+1] <= x_i;
					r_s[i+1]   <= r_i >> 1;
				end
				sd_s[i+1] <= sd_i;
			end
		end
	end

	assign root      = r_s[N][tbik_pkg::CQ_W-1:0];
	assign side_out  = sd_s[N];
	assign valid_out = v_s[N];

endmodule

>>> tb/bend_angle_checker.sv
// Checker for the two-bone bend angle unit: watches both streams, predicts each
// result from the accepted input word and compares. Depends on tbik_pkg only.
`timescale 1ns / 100ps

module bend_angle_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [167:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [23:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	output int           fail_count,
	output int           pending
);
	localparam int STEPS = tbik_pkg::CORDIC_STEPS_DEF;
	localparam longint HALF_PI = 64'sd6746518852;
	localparam longint TWO_PI  = 64'sd26986075409;
	localparam longint INV_GAIN = 64'sd652032874;

	typedef struct packed {
		logic [18:0] angle;
		logic        degen;
	} bend_t;

	bend_t angle_queue[$];

	function automatic longint shr_signed(longint x, int s);
		return x >>> s;
	endfunction

	function automatic longint arctan_q32(int i);
		if (i < 13) return longint'(tbik_pkg::atan_step(i));
		if (i < 32) return 64'sd1 << (32 - i);
		return 0;
	endfunction

	// vectoring CORDIC, returns angle in Q32 and scaled magnitude via xo
	function automatic longint cordic_angle(longint x, longint y, output longint xo);
		longint z, t, xn, yn;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HALF_PI;
			end else begin
				t = x; x = -y; y = t; z = -HALF_PI;
			end
		end
		if (x == 0 && y == 0) begin
			xo = 0;
			return 0;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y >= 0) begin
				xn = x + shr_signed(y, i); yn = y - shr_signed(x, i); z += arctan_q32(i);
			end else begin
				xn = x - shr_signed(y, i); yn = y + shr_signed(x, i); z -= arctan_q32(i);
			end
			x = xn; y = yn;
		end
		xo = x;
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bend_t predict_bend(logic [167:0] w);
		longint mx, my, mz, ex, ey, ez, rr, d2, px, py, c, pang, aang, xf, v, nx, ny;
		longint unsigned dmag, cq, ax, ay, m, mag, dsc, thr, res;
		int k, e;
		bend_t b;
		mx = longint'($signed(w[23:0]));    my = longint'($signed(w[47:24]));
		mz = longint'($signed(w[71:48]));   ex = longint'($signed(w[95:72]));
		ey = longint'($signed(w[119:96]));  ez = longint'($signed(w[143:120]));
		rr = longint'({1'b0, w[166:144]});
		d2 = rr * rr - (mx * mx + my * my + mz * mz) - (ex * ex + ey * ey + ez * ez)
			- 2 * (mx * ex);
		px = my * ey + mz * ez;
		py = my * ez - ey * mz;
		dmag = d2 < 0 ? longint'(-d2) : d2;
		pang = 0;
		b.degen = (px == 0 && py == 0);
		if (b.degen) begin
			cq = (d2 == 0) ? 0 : (64'd1 << 30);
		end else begin
			ax = px < 0 ? -px : px;
			ay = py < 0 ? -py : py;
			m = ax | ay;
			k = 0;
			while (m < (64'd1 << 45)) begin
				m <<= 1; k++;
			end
			nx = ax << k; if (px < 0) nx = -nx;
			ny = ay << k; if (py < 0) ny = -ny;
			pang = cordic_angle(nx, ny, xf);
			mag = ((longint'(xf) >> 17) * INV_GAIN) >> 30;
			e = k - 17;
			if (e >= 0) begin
				thr = (2 * mag + ((64'd1 << e) - 1)) >> e;
				if (dmag >= thr) cq = 64'd1 << 30;
				else begin
					dsc = dmag << e; cq = (dsc << 29) / mag;
				end
			end else begin
				dsc = dmag >> (-e);
				if (dsc >= 2 * mag) cq = 64'd1 << 30;
				else cq = (dsc << 29) / mag;
			end
		end
		c = d2 < 0 ? -longint'(cq) : longint'(cq);
		aang = cordic_angle(c, longint'(int_sqrt((64'd1 << 60) - cq * cq)), xf);
		v = aang - pang;
		if (v <= 0) v = 0;
		if (v > TWO_PI) v = TWO_PI;
		res = (longint'(v) + (64'd1 << (31 - tbik_pkg::ANGLE_FRAC_BITS)))
			>> (32 - tbik_pkg::ANGLE_FRAC_BITS);
		if (res > 64'h7FFFF) res = 64'h7FFFF;
		b.angle = res[18:0];
		return b;
	endfunction

	assign pending = angle_queue.size();

	always @(posedge clk) begin
		bend_t want;
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				angle_queue.insert(angle_queue.size(), predict_bend(s_tdata));
			end
			if (m_tvalid && m_tready) begin
				if (angle_queue.size() == 0) begin
					$error("unexpected word: bend_angle %0d", m_tdata[18:0]);
					fail_count++;
				end else begin
					want = angle_queue.pop_front();
					if (m_tdata[18:0] !== want.angle) begin
						$error("bend_angle: expected %0d, got %0d", want.angle, m_tdata[18:0]);
						fail_count++;
					end
					if (m_tuser[0] !== want.degen) begin
						$error("degenerate: expected %0d, got %0d", want.degen, m_tuser[0]);
						fail_count++;
					end
					if (m_tdata[23:19] !== 5'd0) begin
						$error("pad: expected 0, got %0d", m_tdata[23:19]);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

>>> tb/tb_two_bone_ik_bend_angle_unit.sv
// Top of the bend angle unit testbench: clock, reset, stimulus and verdict.
// Depends on two_bone_ik_bend_angle_unit, bend_angle_checker and tbik_pkg.
`timescale 1ns / 100ps

module tb_two_bone_ik_bend_angle_unit;
	localparam int RANDOM_WORDS = 1030;
	localparam int LIMIT_CYCLES = 200000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [167:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic [0:0]   m_tuser;
	int           fail_count;
	int           pending;
	int           cycle_count;
	int           send_idle_pct;  // chance of an idle cycle on the input side
	int           recv_stall_pct; // chance of a stall on the output side

	two_bone_ik_bend_angle_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	bend_angle_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: stalls at random, rate set by the current phase
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// coordinate: extreme, small or full-range random, mostly moderate so p and d stay comparable
	function automatic logic [23:0] pick_coord();
		case ($urandom_range(9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'($signed($urandom_range(16)) - 8);
			3, 4: return 24'($urandom);
			default: return 24'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// hold one word on the bus until it is taken; idle cycles inserted first
	task automatic send_word(logic [23:0] mx, my, mz, ex, ey, ez, logic [22:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, r, ez, ey, ex, mz, my, mx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [23:0] c[6];
		logic [22:0] r;
		foreach (c[i]) c[i] = pick_coord();
		// mostly a reach near the bone lengths so the clamp is not always hit
		case ($urandom_range(3))
			0: r = 23'($urandom);
			1: r = 23'($urandom_range(8) == 0 ? 23'h7FFFFF : 23'd0);
			default: r = 23'($urandom_range(40000));
		endcase
		send_word(c[0], c[1], c[2], c[3], c[4], c[5], r);
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata  = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero vector, straight chain, all extremes, degenerate cross term
		send_word('0, '0, '0, '0, '0, '0, '0);
		send_word('0, '0, '0, '0, '0, '0, 23'h7FFFFF);
		send_word(24'd4096, '0, '0, 24'd4096, '0, '0, 23'd8192);
		send_word(24'd4096, '0, '0, 24'd4096, '0, '0, 23'd4096);
		send_word(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			23'h7FFFFF);
		send_word(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
			23'h7FFFFF);
		send_word(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, '0);
		send_word('0, 24'd4096, '0, '0, 24'd4096, '0, 23'd5793);
		send_word('0, 24'd4096, '0, '0, '0, 24'd4096, 23'd5793);
		send_word('0, 24'd4096, '0, '0, '0, 24'hFFF000, 23'd5793);
		send_word('0, 24'd4096, '0, '0, 24'hFFF000, '0, 23'd5793);
		send_word('0, 24'd4096, '0, '0, 24'hFFF000, '0, 23'd100);
		send_word('0, 24'd4096, '0, '0, 24'hFFF000, '0, 23'h7FFFFF);
		send_word('0, 24'd1, '0, '0, '0, 24'd1, 23'd2);
		send_word(24'd4096, 24'd4096, '0, '0, '0, '0, 23'd4096);
		send_word(24'd3, 24'd4, 24'd0, 24'd0, 24'd3, 24'd4, 23'd9);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				3: begin send_idle_pct = 30; recv_stall_pct = 30; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			repeat (RANDOM_WORDS / 5) send_random();
		end
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (2 * tbik_pkg::CORDIC_STEPS_DEF + 100) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
